@@ src/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared codes and defaults for the priority task table with aging.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 32;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_CMPL  = 3'd2;
  localparam logic [2:0] OP_AGE   = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_DEPTH = 3'd5;

  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;

  localparam logic [47:0] ONE_LEVEL   = 48'd256000;
  localparam logic [47:0] TWO_LEVEL   = 48'd512000;
  localparam logic [47:0] THREE_LEVEL = 48'd768000;

  localparam logic [15:0] AGING_RESET = 16'd256;

endpackage

@@ src/ptt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] now_time;
  logic [1:0]  task_priority;
  logic [31:0] target_id;
  logic [2:0]  final_status;

  modport source (output valid, op, now_time, task_priority, target_id, final_status,
                  input ready);
  modport sink (input valid, op, now_time, task_priority, target_id, final_status,
                output ready);
endinterface

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] task_id_out;
  logic [1:0]  priority_out;
  logic [31:0] created_out;
  logic [31:0] value_out;
  logic [4:0]  queued_depth;

  modport source (output valid, ok, task_id_out, priority_out, created_out, value_out,
                  queued_depth, input ready);
  modport sink (input valid, ok, task_id_out, priority_out, created_out, value_out,
                queued_depth, output ready);
endinterface

@@ src/ptt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_mem
// Slot table memory, one write and one registered read per cycle; entries
// not written since reset read as zero (free slot).
// ----------------------------------------------------------------------------
module ptt_mem #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF,
  parameter int EW    = 37 + ptt_pkg::ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [EW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [EW-1:0]            rd_data
);

  logic [EW-1:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [EW-1:0] rd_q_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ src/ptt_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_seq
// Operation sequencer: scans every slot through the memory read port,
// selects or ages entries, writes back changes, issues the result beat.
// ----------------------------------------------------------------------------
module ptt_seq #(
  parameter int SLOTS   = ptt_pkg::SLOTS_DEF,
  parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [15:0]              age_rate,
  ptt_in_if.sink                   in_ch,
  ptt_out_if.source                out_ch,
  output logic                     wr_en,
  output logic [$clog2(SLOTS)-1:0] wr_addr,
  output logic [36+ID_BITS:0]      wr_data,
  output logic                     rd_en,
  output logic [$clog2(SLOTS)-1:0] rd_addr,
  input  logic [36+ID_BITS:0]      rd_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = (ID_BITS > 32) ? ID_BITS : 32;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic pend_r, pend_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [31:0] now_r, now_nxt;
  logic [1:0]  prio_r, prio_nxt;
  logic [31:0] target_r, target_nxt;
  logic [2:0]  fstat_r, fstat_nxt;

  logic found_r, found_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt;
  logic [1:0] fprio_r, fprio_nxt;
  logic [31:0] fcreated_r, fcreated_nxt;
  logic [ID_BITS-1:0] fid_r, fid_nxt;
  logic [2:0] fold_r, fold_nxt;
  logic [CW-1:0] changed_r, changed_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;

  logic out_valid_r, out_valid_nxt;
  logic ok_r, ok_nxt;
  logic [31:0] tid_r, tid_nxt;
  logic [1:0] pout_r, pout_nxt;
  logic [31:0] cout_r, cout_nxt;
  logic [31:0] val_r, val_nxt;
  logic [4:0] depth_r, depth_nxt;

  logic [2:0] e_status;
  logic [1:0] e_prio;
  logic [31:0] e_created;
  logic [ID_BITS-1:0] e_id;
  logic [31:0] e_wait;
  logic [47:0] boost;
  logic [1:0] aged_prio;
  logic id_hit;
  logic fin_go;
  logic [31:0] cnt32;

  assign {e_status, e_prio, e_created, e_id} = rd_data;
  assign e_wait = now_r - e_created;
  assign boost  = 48'(e_wait) * 48'(age_rate);
  assign id_hit = (MW'(e_id) == MW'(target_r));
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    aged_prio = e_prio;
    if (boost >= ptt_pkg::ONE_LEVEL && aged_prio == 2'd0) aged_prio = 2'd1;
    if (boost >= ptt_pkg::TWO_LEVEL && aged_prio <= 2'd1) aged_prio = 2'd2;
    if (boost >= ptt_pkg::THREE_LEVEL && aged_prio <= 2'd2) aged_prio = 2'd3;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign rd_en       = (state_r == S_SCAN);
  assign rd_addr     = scan_r;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_nxt      = rd_en;
    ridx_nxt      = scan_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    prio_nxt      = prio_r;
    target_nxt    = target_r;
    fstat_nxt     = fstat_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    fprio_nxt     = fprio_r;
    fcreated_nxt  = fcreated_r;
    fid_nxt       = fid_r;
    fold_nxt      = fold_r;
    changed_nxt   = changed_r;
    cnt_nxt       = cnt_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ok_nxt        = ok_r;
    tid_nxt       = tid_r;
    pout_nxt      = pout_r;
    cout_nxt      = cout_r;
    val_nxt       = val_r;
    depth_nxt     = depth_r;
    wr_en         = 1'b0;
    wr_addr       = ridx_r;
    wr_data       = rd_data;
    cnt32         = '0;

    // latch the operation beat and start the scan
    if (state_r == S_IDLE && in_ch.valid) begin
      op_nxt      = in_ch.op;
      now_nxt     = in_ch.now_time;
      prio_nxt    = in_ch.task_priority;
      target_nxt  = in_ch.target_id;
      fstat_nxt   = in_ch.final_status;
      found_nxt   = 1'b0;
      changed_nxt = '0;
      scan_nxt    = '0;
      state_nxt   = S_SCAN;
    end

    if (state_r == S_SCAN) begin
      scan_nxt = scan_r + AW'(1);
      if (scan_r == LAST) begin
        state_nxt = S_WAIT;
      end
    end
    if (state_r == S_WAIT) begin
      state_nxt = S_FIN;
    end

    // examine the slot returned by the memory
    if (pend_r) begin
      case (op_r)
        ptt_pkg::OP_ENQ: begin
          if (!found_r && e_status != ptt_pkg::ST_QUEUED) begin
            found_nxt = 1'b1;
            fidx_nxt  = ridx_r;
          end
        end
        ptt_pkg::OP_DEQ: begin
          if (e_status == ptt_pkg::ST_QUEUED &&
              (!found_r || e_prio > fprio_r ||
               (e_prio == fprio_r && e_created < fcreated_r))) begin
            found_nxt    = 1'b1;
            fidx_nxt     = ridx_r;
            fprio_nxt    = e_prio;
            fcreated_nxt = e_created;
            fid_nxt      = e_id;
          end
        end
        ptt_pkg::OP_CMPL, ptt_pkg::OP_WAIT: begin
          if (!found_r && id_hit) begin
            found_nxt    = 1'b1;
            fidx_nxt     = ridx_r;
            fprio_nxt    = e_prio;
            fcreated_nxt = e_created;
            fid_nxt      = e_id;
            fold_nxt     = e_status;
          end
        end
        ptt_pkg::OP_AGE: begin
          if (e_status == ptt_pkg::ST_QUEUED && !e_wait[31] && aged_prio != e_prio) begin
            wr_en       = 1'b1;
            wr_data     = {e_status, aged_prio, e_created, e_id};
            changed_nxt = changed_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // write back and issue the result beat
    if (fin_go) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      ok_nxt        = 1'b0;
      tid_nxt       = '0;
      pout_nxt      = '0;
      cout_nxt      = '0;
      val_nxt       = '0;
      wr_addr       = fidx_r;
      case (op_r)
        ptt_pkg::OP_ENQ: begin
          if (cnt_r != FULL && found_r) begin
            wr_en       = 1'b1;
            wr_data     = {ptt_pkg::ST_QUEUED, prio_r, now_r, next_id_r};
            ok_nxt      = 1'b1;
            tid_nxt     = 32'(MW'(next_id_r));
            next_id_nxt = next_id_r + ID_BITS'(1);
            cnt_nxt     = cnt_r + CW'(1);
          end
        end
        ptt_pkg::OP_DEQ: begin
          if (found_r) begin
            wr_en    = 1'b1;
            wr_data  = {ptt_pkg::ST_RUNNING, fprio_r, fcreated_r, fid_r};
            ok_nxt   = 1'b1;
            tid_nxt  = 32'(MW'(fid_r));
            pout_nxt = fprio_r;
            cout_nxt = fcreated_r;
            cnt_nxt  = cnt_r - CW'(1);
          end
        end
        ptt_pkg::OP_CMPL: begin
          if (found_r) begin
            wr_en   = 1'b1;
            wr_data = {fstat_r, fprio_r, fcreated_r, fid_r};
            ok_nxt  = 1'b1;
            cnt_nxt = cnt_r - CW'(fold_r == ptt_pkg::ST_QUEUED)
                            + CW'(fstat_r == ptt_pkg::ST_QUEUED);
          end
        end
        ptt_pkg::OP_AGE: begin
          ok_nxt  = 1'b1;
          val_nxt = 32'(changed_r);
        end
        ptt_pkg::OP_WAIT: begin
          if (found_r) begin
            ok_nxt  = 1'b1;
            val_nxt = now_r - fcreated_r;
          end
        end
        ptt_pkg::OP_DEPTH: begin
          ok_nxt = 1'b1;
        end
        default: begin
        end
      endcase
      cnt32     = 32'(cnt_nxt);
      depth_nxt = (cnt32 > 32'd31) ? 5'd31 : cnt32[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      changed_r   <= '0;
      cnt_r       <= '0;
      next_id_r   <= ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      changed_r   <= changed_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r     <= ridx_nxt;
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    prio_r     <= prio_nxt;
    target_r   <= target_nxt;
    fstat_r    <= fstat_nxt;
    fidx_r     <= fidx_nxt;
    fprio_r    <= fprio_nxt;
    fcreated_r <= fcreated_nxt;
    fid_r      <= fid_nxt;
    fold_r     <= fold_nxt;
    ok_r       <= ok_nxt;
    tid_r      <= tid_nxt;
    pout_r     <= pout_nxt;
    cout_r     <= cout_nxt;
    val_r      <= val_nxt;
    depth_r    <= depth_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.task_id_out  = tid_r;
  assign out_ch.priority_out = pout_r;
  assign out_ch.created_out  = cout_r;
  assign out_ch.value_out    = val_r;
  assign out_ch.queued_depth = depth_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("queued count exceeds slot count");

  a_scan_write_age: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !fin_go) |-> (op_r == ptt_pkg::OP_AGE))
    else $error("scan write outside age");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && op_r == ptt_pkg::OP_DEQ && found_r) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("dequeue did not lower queued count");

  a_enq_id: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && op_r == ptt_pkg::OP_ENQ && ok_nxt) |=>
      (next_id_r == $past(next_id_r) + ID_BITS'(1)))
    else $error("enqueue did not advance id");

  a_fin_beat: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && state_r == S_IDLE))
    else $error("finish without result beat");

endmodule

@@ src/priority_task_table_with_aging_top.sv @@
`timescale 1ns / 1ps
// An operation beat is taken only in idle; the sequencer then scans every slot through the
// single memory read port, passes a wait state and writes back in the finish state, which
// issues the result beat and holds while the previous result has not been taken.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active low) frees every slot at once through valid bits,
// sets the next id to 1 and the aging factor to 256; no clearing pass.
// ----------------------------------------------------------------------------
// priority_task_table_with_aging_top
// Task slot table with priority dequeue, completion, aging and queries.
// ----------------------------------------------------------------------------
module priority_task_table_with_aging_top #(
  parameter int SLOTS   = ptt_pkg::SLOTS_DEF,
  parameter int ID_BITS = ptt_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ptt_in_if.sink      in_ch,
  ptt_out_if.source   out_ch
);

  localparam int AW = $clog2(SLOTS);
  localparam int EW = 37 + ID_BITS;

  logic [15:0] aging_r, aging_nxt;
  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  assign aging_nxt = cfg_we ? cfg_wdata : aging_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r <= ptt_pkg::AGING_RESET;
    end else begin
      aging_r <= aging_nxt;
    end
  end

  ptt_mem #(.SLOTS(SLOTS), .EW(EW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptt_seq #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .age_rate     (aging_r),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

endmodule

@@ bench/tb_priority_task_table_with_aging_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_task_table_with_aging_top
// Self-checking bench for the task table: a directed table of operations,
// then random enqueue-heavy traffic with random gaps on both channels. Each
// result beat is compared against an in-bench model of slots, ids and aging.
// ----------------------------------------------------------------------------
module tb_priority_task_table_with_aging_top;

  localparam int NSLOT = 16;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [2:0] ST_DONE = 3'd3;

  typedef struct packed {
    logic        ok;
    logic [31:0] task_id;
    logic [1:0]  prio;
    logic [31:0] created;
    logic [31:0] value;
    logic [4:0]  depth;
  } result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_time;
    logic [1:0]  prio;
    logic [31:0] target;
    logic [2:0]  fstat;
    logic        has_exp;
    result_t     exp_res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  ptt_in_if  in_ch();
  ptt_out_if out_ch();

  priority_task_table_with_aging_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [2:0]  tbl_status [NSLOT];
  logic [1:0]  tbl_prio [NSLOT];
  logic [31:0] tbl_created [NSLOT];
  logic [31:0] tbl_id [NSLOT];
  logic [31:0] id_counter;
  logic [15:0] aging_rate;

  result_t pending_results[$];
  result_t typed_results[$];
  logic    typed_flags[$];
  int mismatches = 0;
  int cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  function automatic int queued_count();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (tbl_status[i] == ptt_pkg::ST_QUEUED) n++;
    return n;
  endfunction

  function automatic int find_slot_by_id(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic result_t predict_table_op(op_row_t r);
    result_t res;
    int pos;
    logic [31:0] wait_ms;
    logic [47:0] boost;
    logic [1:0] p;
    logic [31:0] changed;
    res = '0;
    case (r.op)
      ptt_pkg::OP_ENQ: begin
        if (queued_count() < NSLOT) begin
          pos = -1;
          for (int i = 0; i < NSLOT; i++)
            if (pos < 0 && tbl_status[i] != ptt_pkg::ST_QUEUED) pos = i;
          tbl_status[pos] = ptt_pkg::ST_QUEUED;
          tbl_prio[pos] = r.prio;
          tbl_created[pos] = r.now_time;
          tbl_id[pos] = id_counter;
          id_counter = id_counter + 1;
          res.ok = 1'b1;
          res.task_id = tbl_id[pos];
        end
      end
      ptt_pkg::OP_DEQ: begin
        pos = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_status[i] == ptt_pkg::ST_QUEUED &&
              (pos < 0 || tbl_prio[i] > tbl_prio[pos] ||
               (tbl_prio[i] == tbl_prio[pos] && tbl_created[i] < tbl_created[pos])))
            pos = i;
        end
        if (pos >= 0) begin
          tbl_status[pos] = ptt_pkg::ST_RUNNING;
          res.ok = 1'b1;
          res.task_id = tbl_id[pos];
          res.prio = tbl_prio[pos];
          res.created = tbl_created[pos];
        end
      end
      ptt_pkg::OP_CMPL: begin
        pos = find_slot_by_id(r.target);
        if (pos >= 0) begin
          tbl_status[pos] = r.fstat;
          res.ok = 1'b1;
        end
      end
      ptt_pkg::OP_AGE: begin
        changed = 0;
        for (int i = 0; i < NSLOT; i++) begin
          wait_ms = r.now_time - tbl_created[i];
          if (tbl_status[i] == ptt_pkg::ST_QUEUED && !wait_ms[31]) begin
            boost = 48'(wait_ms) * 48'(aging_rate);
            p = tbl_prio[i];
            if (boost >= ptt_pkg::ONE_LEVEL && p == 2'd0) p = 2'd1;
            if (boost >= ptt_pkg::TWO_LEVEL && p <= 2'd1) p = 2'd2;
            if (boost >= ptt_pkg::THREE_LEVEL && p <= 2'd2) p = 2'd3;
            if (p != tbl_prio[i]) changed++;
            tbl_prio[i] = p;
          end
        end
        res.ok = 1'b1;
        res.value = changed;
      end
      ptt_pkg::OP_WAIT: begin
        pos = find_slot_by_id(r.target);
        if (pos >= 0) begin
          res.ok = 1'b1;
          res.value = r.now_time - tbl_created[pos];
        end
      end
      ptt_pkg::OP_DEPTH: res.ok = 1'b1;
      default: ;
    endcase
    res.depth = 5'(queued_count());
    return res;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_status[i] = ptt_pkg::ST_FREE;
      tbl_prio[i] = '0;
      tbl_created[i] = '0;
      tbl_id[i] = '0;
    end
    id_counter = 32'd1;
    aging_rate = ptt_pkg::AGING_RESET;
  endtask

  task automatic send_op(op_row_t r);
    result_t res;
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= r.op;
    in_ch.now_time <= r.now_time;
    in_ch.task_priority <= r.prio;
    in_ch.target_id <= r.target;
    in_ch.final_status <= r.fstat;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_table_op(r);
    pending_results.push_back(res);
    typed_results.push_back(r.exp_res);
    typed_flags.push_back(r.has_exp);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    aging_rate = v;
  endtask

  function automatic op_row_t mk(logic [2:0] op, logic [31:0] t, logic [1:0] p,
                                 logic [31:0] tg, logic [2:0] fs);
    op_row_t r;
    r = '0;
    r.op = op; r.now_time = t; r.prio = p; r.target = tg; r.fstat = fs;
    return r;
  endfunction

  function automatic op_row_t mk_exp(op_row_t r, logic ok, logic [31:0] id,
                                     logic [4:0] d);
    r.has_exp = 1'b1;
    r.exp_res = '0;
    r.exp_res.ok = ok;
    r.exp_res.task_id = id;
    r.exp_res.depth = d;
    return r;
  endfunction

  op_row_t directed[$];

  // result side: random stalls, compare against oldest expectation
  initial begin
    result_t got, want, typed;
    logic has_typed;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.ok, out_ch.task_id_out, out_ch.priority_out, out_ch.created_out,
             out_ch.value_out, out_ch.queued_depth};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_results.pop_front();
        typed = typed_results.pop_front();
        has_typed = typed_flags.pop_front();
        if (got != want || (has_typed && got != typed)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: ok %b/%b id %h/%h prio %0d/%0d",
                     want.ok, got.ok, want.task_id, got.task_id, want.prio, got.prio,
                     " created %h/%h value %h/%h depth %0d/%0d",
                     want.created, got.created, want.value, got.value,
                     want.depth, got.depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("priority_task_table_with_aging_top regression: fail");
      $finish;
    end
  end

  initial begin
    op_row_t r;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.now_time = '0;
    in_ch.task_priority = '0;
    in_ch.target_id = '0;
    in_ch.final_status = '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_exp(mk(ptt_pkg::OP_DEPTH, 0, 0, 0, 0), 1, 0, 0));
    directed.push_back(mk_exp(mk(ptt_pkg::OP_DEQ, 0, 0, 0, 0), 0, 0, 0));
    directed.push_back(mk_exp(mk(ptt_pkg::OP_WAIT, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0),
                              0, 0, 0));
    directed.push_back(mk_exp(mk(ptt_pkg::OP_CMPL, 0, 0, 32'hDEAD_BEEF, ST_DONE), 0, 0, 0));
    directed.push_back(mk_exp(mk(OP_BAD6, 5, 3, 0, 7), 0, 0, 0));
    directed.push_back(mk_exp(mk(OP_BAD7, 5, 3, 0, 7), 0, 0, 0));
    directed.push_back(mk(ptt_pkg::OP_WAIT, 32'd77, 0, 0, 0));
    for (int i = 0; i < NSLOT; i++)
      directed.push_back(mk_exp(mk(ptt_pkg::OP_ENQ, 32'hFFFF_FFF0 + i, 2'(i), 0, 0),
                                1, 32'(i + 1), 5'(i + 1)));
    directed.push_back(mk_exp(mk(ptt_pkg::OP_ENQ, 0, 3, 0, 0), 0, 0, 16));
    directed.push_back(mk(ptt_pkg::OP_AGE, 32'h0000_1000, 0, 0, 0));
    directed.push_back(mk(ptt_pkg::OP_DEQ, 0, 0, 0, 0));
    directed.push_back(mk(ptt_pkg::OP_CMPL, 0, 0, 32'd3, 3'd7));
    directed.push_back(mk(ptt_pkg::OP_WAIT, 32'd100, 0, 32'd5, 0));
    foreach (directed[i]) send_op(directed[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_rate(16'd0);
        1: write_rate(16'hFFFF);
        2: write_rate(16'd1);
        3: write_rate(16'(($urandom_range(0, 65535))));
        default: write_rate(ptt_pkg::AGING_RESET);
      endcase
      for (int n = 0; n < 130; n++) begin
        kind = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 4000);
        r = mk(ptt_pkg::OP_DEPTH, clock_ms, 2'($urandom_range(0, 3)), 0,
               3'($urandom_range(0, 7)));
        if ($urandom_range(0, 19) == 0) r.now_time = $urandom;
        if (kind < 35) r.op = ptt_pkg::OP_ENQ;
        else if (kind < 55) r.op = ptt_pkg::OP_DEQ;
        else if (kind < 70) r.op = ptt_pkg::OP_CMPL;
        else if (kind < 82) r.op = ptt_pkg::OP_AGE;
        else if (kind < 94) r.op = ptt_pkg::OP_WAIT;
        else r.op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 4) == 0) r.target = $urandom;
        else if ($urandom_range(0, 9) == 0) r.target = 0;
        else r.target = id_counter - $urandom_range(1, 20);
        send_op(r);
      end
      drain();
    end
    if (mismatches == 0)
      $display("priority_task_table_with_aging_top regression: pass");
    else
      $display("priority_task_table_with_aging_top regression: fail");
    $finish;
  end
endmodule
